/* rtl/tile_map_edge_collision_probe_macros.svh */
// ----------------------------------------------------------------------------
// Tile map edge collision probe assertion macros
// Shorthand for the concurrent checks of the probe top level.
// ----------------------------------------------------------------------------
`ifndef TILE_MAP_EDGE_COLLISION_PROBE_MACROS_SVH
`define TILE_MAP_EDGE_COLLISION_PROBE_MACROS_SVH

// Checked on every rising edge outside of reset.
`define TMECP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define TMECP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/tmecp_pkg.sv */
// ----------------------------------------------------------------------------
// Tile map edge collision probe package
// Widths, codes and reset values shared by the probe and its interfaces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmecp_pkg;

  localparam int MapTiles = 4096;
  localparam int MapAw    = $clog2(MapTiles);

  localparam int OpW       = 3;
  localparam int TileAddrW = 12;
  localparam int TileW     = 8;
  localparam int PosXW     = 16;
  localparam int PosYW     = 11;
  localparam int BoxW      = 8;
  localparam int PixW      = 16;
  localparam int IdxW      = 16;
  localparam int MapWidthW = 13;
  localparam int RowW      = 8;
  localparam int SmpW      = BoxW - 3;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = MapWidthW;

  localparam logic [MapWidthW-1:0] MapWidthRst = 13'd32;
  localparam logic [TileW-1:0]     FreeARst    = 8'h00;
  localparam logic [TileW-1:0]     FreeBRst    = 8'h13;

  typedef enum logic [OpW-1:0] {
    OP_WRITE = 3'd0,
    OP_DOWN  = 3'd1,
    OP_UP    = 3'd2,
    OP_RIGHT = 3'd3,
    OP_LEFT  = 3'd4
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAP_WIDTH   = 2'd0,
    CFG_FREE_CODE_A = 2'd1,
    CFG_FREE_CODE_B = 2'd2
  } cfg_reg_e;

endpackage

/* rtl/tmecp_intf.sv */
// ----------------------------------------------------------------------------
// Tile map edge collision probe channels
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tmecp_in_if;
  import tmecp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OpW-1:0]       opcode;
  logic [TileAddrW-1:0] tile_addr;
  logic [TileW-1:0]     tile_value;
  logic [PosXW-1:0]     pos_x;
  logic [PosYW-1:0]     pos_y;
  logic [BoxW-1:0]      box_w;
  logic [BoxW-1:0]      box_h;

  modport source (
    output valid, opcode, tile_addr, tile_value, pos_x, pos_y, box_w, box_h,
    input  ready
  );
  modport sink (
    input  valid, opcode, tile_addr, tile_value, pos_x, pos_y, box_w, box_h,
    output ready
  );
endinterface

interface tmecp_out_if;
  import tmecp_pkg::*;

  logic            valid;
  logic            ready;
  logic            hit;
  logic [IdxW-1:0] tile_index;

  modport source (output valid, hit, tile_index, input ready);
  modport sink (input valid, hit, tile_index, output ready);
endinterface

/* rtl/tile_map_edge_collision_probe.sv */
// ----------------------------------------------------------------------------
// Tile map edge collision probe
// Byte-per-tile map loaded by write words; probe words walk one box edge
// through a single address/multiply unit and a one-port-read tile memory.
// ----------------------------------------------------------------------------
// A probe word is taken in the idle state and its edge is set up; the walk
// then issues one tile memory read per cycle until a sample blocks or the last
// sample is checked, and the result word is registered out of the post state.
// Throughput: one write word per cycle while idle; a probe word holds the input
// off until its result leaves the post state.
// Reset clears the sequencer, the output register and the configuration
// registers; the tile map is not cleared and must be written before use.
`timescale 1ns / 1ps
`include "tile_map_edge_collision_probe_macros.svh"

module tile_map_edge_collision_probe (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tmecp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tmecp_pkg::CfgDataW-1:0] cfg_wdata_i,
  tmecp_in_if.sink                     in_i,
  tmecp_out_if.source                  out_o
);
  import tmecp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_POST  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [MapWidthW-1:0] map_width_q;
  logic [TileW-1:0]     free_a_q, free_b_q;

  logic [TileW-1:0] mem [MapTiles];
  logic             mem_we;
  logic [MapAw-1:0] mem_raddr;
  logic [TileW-1:0] rd_data_q;

  logic [OpW-1:0]   op_q;
  logic [PosXW-1:0] x_q;
  logic [PosYW-1:0] y_q;
  logic [BoxW-1:0]  w_q, h_q;

  logic             vert_q;
  logic [PixW-1:0]  fix_pix_q, base_q;
  logic [SmpW-1:0]  lim_q, smp_q;
  logic [BoxW-1:0]  off_q;
  logic             iss_act_q;
  logic             chk_vld_q, chk_last_q, chk_inr_q;
  logic [IdxW-1:0]  chk_idx_q;
  logic             res_hit_q;
  logic [IdxW-1:0]  res_idx_q;

  logic            out_valid_q, out_hit_q;
  logic [IdxW-1:0] out_idx_q;

  logic                 in_acc;
  logic [PixW-1:0]      walk_pix, col_pix, row_pix;
  logic [RowW-1:0]      row;
  logic [PixW-4:0]      col;
  logic [RowW+MapWidthW-1:0] prod;
  logic [IdxW-1:0]      idx;
  logic                 idx_inr;
  logic                 blocking;
  logic                 finish;

  assign in_i.ready       = (state_q == ST_IDLE);
  assign in_acc           = in_i.valid && in_i.ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.hit        = out_hit_q;
  assign out_o.tile_index = out_idx_q;

  assign mem_we = in_acc && (in_i.opcode == OP_WRITE) &&
                  ({1'b0, 16'(in_i.tile_addr)} < 17'(MapTiles));

  assign walk_pix  = base_q + PixW'(off_q);
  assign col_pix   = vert_q ? fix_pix_q : walk_pix;
  assign row_pix   = vert_q ? walk_pix : fix_pix_q;
  assign col       = col_pix[PixW-1:3];
  assign row       = row_pix[RowW+2:3];
  assign prod      = (RowW+MapWidthW)'(row) * (RowW+MapWidthW)'(map_width_q);
  assign idx       = prod[IdxW-1:0] + IdxW'(col);
  assign idx_inr   = ({1'b0, idx} < 17'(MapTiles));
  assign mem_raddr = idx[MapAw-1:0];

  assign blocking = chk_inr_q && (rd_data_q != free_a_q) && (rd_data_q != free_b_q);
  assign finish   = chk_vld_q && (blocking || chk_last_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[in_i.tile_addr[MapAw-1:0]] <= in_i.tile_value;
    end
    rd_data_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q <= MapWidthRst;
      free_a_q    <= FreeARst;
      free_b_q    <= FreeBRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAP_WIDTH:   map_width_q <= cfg_wdata_i;
        CFG_FREE_CODE_A: free_a_q    <= cfg_wdata_i[TileW-1:0];
        CFG_FREE_CODE_B: free_b_q    <= cfg_wdata_i[TileW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_i.opcode == OP_DOWN || in_i.opcode == OP_UP ||
                       in_i.opcode == OP_RIGHT || in_i.opcode == OP_LEFT)) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: state_d = ST_WALK;
      ST_WALK: begin
        if (finish) begin
          state_d = ST_POST;
        end
      end
      ST_POST: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iss_act_q   <= 1'b0;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_POST && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_SETUP: begin
          iss_act_q <= 1'b1;
          chk_vld_q <= 1'b0;
        end
        ST_WALK: begin
          if (finish) begin
            iss_act_q <= 1'b0;
            chk_vld_q <= 1'b0;
          end else begin
            chk_vld_q <= iss_act_q;
            if (iss_act_q && smp_q == lim_q) begin
              iss_act_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= in_i.opcode;
      x_q  <= in_i.pos_x;
      y_q  <= in_i.pos_y;
      w_q  <= in_i.box_w;
      h_q  <= in_i.box_h;
    end
    if (state_q == ST_SETUP) begin
      smp_q <= '0;
      off_q <= '0;
      priority if (op_q == OP_DOWN) begin
        vert_q    <= 1'b0;
        fix_pix_q <= PixW'(y_q) + PixW'(h_q) - PixW'(1);
        base_q    <= x_q;
        lim_q     <= w_q[BoxW-1:3];
      end else if (op_q == OP_UP) begin
        vert_q    <= 1'b0;
        fix_pix_q <= PixW'(y_q);
        base_q    <= x_q;
        lim_q     <= w_q[BoxW-1:3];
      end else if (op_q == OP_RIGHT) begin
        vert_q    <= 1'b1;
        fix_pix_q <= x_q + PixW'(w_q) - PixW'(1);
        base_q    <= PixW'(y_q);
        lim_q     <= h_q[BoxW-1:3];
      end else begin
        vert_q    <= 1'b1;
        fix_pix_q <= x_q;
        base_q    <= PixW'(y_q);
        lim_q     <= h_q[BoxW-1:3];
      end
    end
    if (state_q == ST_WALK) begin
      if (iss_act_q) begin
        chk_idx_q  <= idx;
        chk_inr_q  <= idx_inr;
        chk_last_q <= (smp_q == lim_q);
        if (smp_q != lim_q) begin
          smp_q <= smp_q + SmpW'(1);
          off_q <= (smp_q == '0) ? BoxW'(7) : off_q + BoxW'(8);
        end
      end
      if (finish) begin
        res_hit_q <= blocking;
        res_idx_q <= blocking ? chk_idx_q : '0;
      end
    end
    if (state_q == ST_POST && (!out_valid_q || out_o.ready)) begin
      out_hit_q <= res_hit_q;
      out_idx_q <= res_idx_q;
    end
  end

  `TMECP_ASSERT(a_out_from_post, $rose(out_valid_q) |-> $past(state_q) == ST_POST, "result word not from post state")
  `TMECP_ASSERT_ALWAYS(a_miss_zero_idx, out_valid_q && !out_hit_q |-> out_idx_q == '0, "miss carries nonzero index")
  `TMECP_ASSERT(a_hit_in_map, out_valid_q && out_hit_q |-> {1'b0, out_idx_q} < 17'(MapTiles), "hit index beyond the map")
  `TMECP_ASSERT(a_smp_in_range, state_q == ST_WALK |-> smp_q <= lim_q, "sample counter past edge length")

endmodule

/* tb/tb_tile_map_edge_collision_probe.sv */
// ----------------------------------------------------------------------------
// Tile map edge collision probe testbench
// Loads the tile map with write words and sends probe words along all four
// box edges, under several map widths and free codes and with random gaps on
// both channels. A model of the probe in this file predicts each result word,
// and a checker compares every result word with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tile_map_edge_collision_probe;
  import tmecp_pkg::*;

  localparam int SettleCycles = 40;
  localparam int IdleLimit    = 20000;
  localparam int TotalWords   = 650;
  localparam int StallCycles  = 300;
  localparam int MaxPrinted   = 50;

  typedef struct packed {
    logic [OpW-1:0]       op;
    logic [TileAddrW-1:0] addr;
    logic [TileW-1:0]     code;
    logic [PosXW-1:0]     pos_x;
    logic [PosYW-1:0]     pos_y;
    logic [BoxW-1:0]      box_w;
    logic [BoxW-1:0]      box_h;
  } probe_word_t;

  typedef struct packed {
    logic            hit;
    logic [IdxW-1:0] index;
  } collision_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  tmecp_in_if  in_if ();
  tmecp_out_if out_if ();

  tile_map_edge_collision_probe dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  logic [TileW-1:0]     map_copy [MapTiles];
  bit                   map_loaded [MapTiles];
  logic [MapWidthW-1:0] row_pitch;
  logic [TileW-1:0]     free_a;
  logic [TileW-1:0]     free_b;

  collision_t awaited_collisions [$];
  collision_t head;

  int err_count     = 0;
  int words_sent    = 0;
  int results_seen  = 0;
  int hits_seen     = 0;
  int settings_used = 0;
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int hold_left     = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic report(string msg);
    err_count++;
    if (err_count <= MaxPrinted) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
  endtask

  function automatic int unsigned sample_count(probe_word_t w);
    logic [BoxW-1:0] extent;
    extent = (w.op == OP_DOWN || w.op == OP_UP) ? w.box_w : w.box_h;
    return (extent >> 3) + 1;
  endfunction

  function automatic logic [IdxW-1:0] edge_tile(probe_word_t w, int unsigned s);
    int unsigned     off;
    int unsigned     col;
    int unsigned     row;
    logic [PixW-1:0] colpix;
    logic [PixW-1:0] rowpix;
    off = (s == 0) ? 0 : s * 8 - 1;
    if (w.op == OP_DOWN || w.op == OP_UP) begin
      colpix = PixW'(w.pos_x + off);
      if (w.op == OP_DOWN) begin
        rowpix = PixW'(w.pos_y + w.box_h - 1);
      end else begin
        rowpix = PixW'(w.pos_y);
      end
    end else begin
      if (w.op == OP_RIGHT) begin
        colpix = PixW'(w.pos_x + w.box_w - 1);
      end else begin
        colpix = w.pos_x;
      end
      rowpix = PixW'(w.pos_y + off);
    end
    col = 32'(colpix >> 3);
    row = 32'((rowpix >> 3) & 16'h00FF);
    return IdxW'(row * row_pitch + col);
  endfunction

  function automatic logic tile_blocks(logic [IdxW-1:0] idx);
    if (idx >= MapTiles) return 1'b0;
    return map_copy[idx[MapAw-1:0]] != free_a && map_copy[idx[MapAw-1:0]] != free_b;
  endfunction

  function automatic collision_t predict_collision(probe_word_t w);
    collision_t      r;
    logic [IdxW-1:0] idx;
    r.hit   = 1'b0;
    r.index = '0;
    for (int unsigned s = 0; s < sample_count(w); s++) begin
      idx = edge_tile(w, s);
      if (tile_blocks(idx)) begin
        r.hit   = 1'b1;
        r.index = idx;
        break;
      end
    end
    return r;
  endfunction

  function automatic logic [TileW-1:0] pick_code();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 4) return free_a;
    if (r < 6) return free_b;
    return TileW'($urandom_range(255));
  endfunction

  function automatic logic [BoxW-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 90) return BoxW'($urandom_range(40, 1));
    return BoxW'($urandom_range(255, 41));
  endfunction

  function automatic probe_word_t random_word(logic [OpW-1:0] op);
    probe_word_t w;
    w.op    = op;
    w.addr  = TileAddrW'($urandom_range(MapTiles - 1));
    w.code  = TileW'($urandom_range(255));
    w.pos_x = PosXW'($urandom_range(16'hFFFF));
    w.pos_y = PosYW'($urandom_range(11'h7FF));
    w.box_w = BoxW'($urandom_range(255));
    w.box_h = BoxW'($urandom_range(255));
    return w;
  endfunction

  function automatic probe_word_t random_item();
    probe_word_t w;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 22) begin
      w = random_word(OP_WRITE);
      w.code = pick_code();
    end else if (r < 24) begin
      w = random_word(OpW'($urandom_range(7, 5)));
    end else begin
      w = random_word(OpW'($urandom_range(OP_LEFT, OP_DOWN)));
      if ($urandom_range(4) != 0) w.pos_x = PosXW'($urandom_range(511));
      if ($urandom_range(9) < 3) w.pos_y = PosYW'($urandom_range(15));
      w.box_w = pick_size();
      w.box_h = pick_size();
    end
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(probe_word_t w);
    while ($urandom_range(99) < src_idle_pct) @(negedge clk_i);
    in_if.opcode     = w.op;
    in_if.tile_addr  = w.addr;
    in_if.tile_value = w.code;
    in_if.pos_x      = w.pos_x;
    in_if.pos_y      = w.pos_y;
    in_if.box_w      = w.box_w;
    in_if.box_h      = w.box_h;
    in_if.valid      = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    if (w.op == OP_WRITE) begin
      map_copy[w.addr]   = w.code;
      map_loaded[w.addr] = 1'b1;
    end else if (w.op <= OP_LEFT) begin
      awaited_collisions.push_back(predict_collision(w));
    end
    words_sent++;
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  task automatic load_tile(logic [TileAddrW-1:0] addr, logic [TileW-1:0] code);
    probe_word_t w;
    w      = random_word(OP_WRITE);
    w.addr = addr;
    w.code = code;
    send_word(w);
  endtask

  // Every in-map entry that the walk will check gets written first.
  task automatic probe_edge(probe_word_t w);
    logic [IdxW-1:0] idx;
    for (int unsigned s = 0; s < sample_count(w); s++) begin
      idx = edge_tile(w, s);
      if (idx < MapTiles) begin
        if (!map_loaded[idx[MapAw-1:0]]) load_tile(idx[MapAw-1:0], pick_code());
        if (tile_blocks(idx)) break;
      end
    end
    send_word(w);
  endtask

  task automatic wait_idle();
    int waited;
    waited = 0;
    while (awaited_collisions.size() != 0 && waited < IdleLimit) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(negedge clk_i);
    if (awaited_collisions.size() != 0) begin
      report($sformatf("%0d result words never arrived", awaited_collisions.size()));
      awaited_collisions.delete();
    end
  endtask

  task automatic write_reg(cfg_reg_e r, logic [CfgDataW-1:0] d);
    cfg_idx   = r;
    cfg_wdata = d;
    cfg_we    = 1'b1;
    @(negedge clk_i);
    cfg_we    = 1'b0;
    case (r)
      CFG_MAP_WIDTH: begin
        row_pitch = d;
      end
      CFG_FREE_CODE_A: begin
        free_a = d[TileW-1:0];
      end
      default: begin
        free_b = d[TileW-1:0];
      end
    endcase
  endtask

  task automatic apply_setting(logic [CfgDataW-1:0] width, logic [TileW-1:0] a,
                               logic [TileW-1:0] b);
    wait_idle();
    write_reg(CFG_MAP_WIDTH, width);
    write_reg(CFG_FREE_CODE_A, CfgDataW'(a));
    write_reg(CFG_FREE_CODE_B, CfgDataW'(b));
    settings_used++;
  endtask

  task automatic run_items(int n);
    probe_word_t w;
    for (int i = 0; i < n; i++) begin
      w = random_item();
      if (w.op >= OP_DOWN && w.op <= OP_LEFT) begin
        probe_edge(w);
      end else begin
        send_word(w);
      end
    end
  endtask

  task automatic test_reset_defaults();
    probe_word_t w;
    load_tile(12'd33, 8'h42);
    w       = random_word(OP_DOWN);
    w.pos_x = '0;
    w.pos_y = '0;
    w.box_w = 8'd16;
    w.box_h = 8'd16;
    probe_edge(w);
    w.op = OP_UP;
    probe_edge(w);
  endtask

  task automatic test_each_edge();
    opcode_e     edges [4];
    probe_word_t w;
    edges = '{OP_DOWN, OP_UP, OP_RIGHT, OP_LEFT};
    load_tile(12'd97, free_b);
    load_tile(12'd98, free_a);
    load_tile(12'd67, free_b);
    load_tile(12'd99, 8'h5A);
    for (int k = 0; k < 4; k++) begin
      w       = random_word(edges[k]);
      w.pos_x = 16'd8;
      w.pos_y = 11'd8;
      w.box_w = 8'd24;
      w.box_h = 8'd24;
      probe_edge(w);
    end
  endtask

  task automatic test_field_extremes();
    opcode_e     edges [4];
    probe_word_t w;
    edges = '{OP_DOWN, OP_UP, OP_RIGHT, OP_LEFT};
    for (int k = 0; k < 4; k++) begin
      w       = random_word(edges[k]);
      w.pos_x = 16'hFFFF;
      w.pos_y = 11'h7FF;
      w.box_w = 8'hFF;
      w.box_h = 8'hFF;
      probe_edge(w);
    end
    // A zero size puts the bottom row and the right column below zero.
    w       = random_word(OP_DOWN);
    w.pos_y = '0;
    w.box_w = '0;
    w.box_h = '0;
    probe_edge(w);
    w       = random_word(OP_RIGHT);
    w.pos_x = '0;
    w.box_w = '0;
    w.box_h = '0;
    probe_edge(w);
    w       = random_word(OP_LEFT);
    w.pos_x = '0;
    w.pos_y = '0;
    w.box_w = 8'd1;
    w.box_h = 8'd1;
    probe_edge(w);
  endtask

  task automatic test_unused_and_last_tile();
    probe_word_t w;
    for (int op = 5; op < 8; op++) begin
      send_word(random_word(OpW'(op)));
    end
    load_tile(12'hFFF, 8'hFF);
    w       = random_word(OP_UP);
    w.pos_x = 16'd248;
    w.pos_y = 11'd1016;
    w.box_w = 8'd1;
    w.box_h = 8'd1;
    probe_edge(w);
  endtask

  task automatic test_zero_width();
    probe_word_t w;
    apply_setting('0, FreeARst, FreeBRst);
    w       = random_word(OP_DOWN);
    w.pos_x = 16'd64;
    w.pos_y = 11'd80;
    w.box_w = 8'd32;
    w.box_h = 8'd8;
    probe_edge(w);
    w.op = OP_RIGHT;
    probe_edge(w);
    apply_setting(MapWidthRst, FreeARst, FreeBRst);
  endtask

  // The receiver holds off long enough for the probe to fill up and stall
  // its input while words keep coming.
  task automatic test_back_pressure();
    wait_idle();
    @(posedge clk_i);
    hold_left = StallCycles;
    @(negedge clk_i);
    run_items(40);
    wait_idle();
  endtask

  // The remaining word budget is split evenly over the six settings.
  task automatic test_random_settings();
    logic [CfgDataW-1:0] widths [6];
    logic [TileW-1:0]    codes_a [6];
    logic [TileW-1:0]    codes_b [6];
    int                  start_words;
    int                  span;
    int                  phase_end;
    widths  = '{13'd32, 13'd1, 13'd4096, 13'd0, 13'h1FFF, 13'd64};
    codes_a = '{8'h00, 8'hFF, 8'h13, 8'h55, 8'h80, 8'h01};
    codes_b = '{8'h13, 8'h00, 8'hAB, 8'h55, 8'h7F, 8'hFE};
    start_words = words_sent;
    span        = TotalWords - start_words;
    if (span < 120) span = 120;
    for (int k = 0; k < 6; k++) begin
      case (k / 2)
        0: begin
          src_idle_pct  = 23;
          sink_idle_pct = 57;
        end
        1: begin
          src_idle_pct  = 57;
          sink_idle_pct = 23;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      apply_setting(widths[k], codes_a[k], codes_b[k]);
      phase_end = start_words + span * (k + 1) / 6;
      while (words_sent < phase_end) run_items(1);
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_if.ready = 1'b0;
      hold_left--;
    end else begin
      out_if.ready = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (awaited_collisions.size() == 0) begin
        report($sformatf("result word hit %0b index %0d with no probe outstanding",
                         out_if.hit, out_if.tile_index));
      end else begin
        head = awaited_collisions.pop_front();
        results_seen++;
        if (head.hit) hits_seen++;
        if (out_if.hit !== head.hit) begin
          report($sformatf("hit %b, expected %b", out_if.hit, head.hit));
        end
        if (out_if.tile_index !== head.index) begin
          report($sformatf("tile index %0d, expected %0d", out_if.tile_index, head.index));
        end
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_MAP_WIDTH;
    cfg_wdata        = '0;
    in_if.valid      = 1'b0;
    in_if.opcode     = OP_WRITE;
    in_if.tile_addr  = '0;
    in_if.tile_value = '0;
    in_if.pos_x      = '0;
    in_if.pos_y      = '0;
    in_if.box_w      = '0;
    in_if.box_h      = '0;
    out_if.ready     = 1'b0;
    row_pitch        = MapWidthRst;
    free_a           = FreeARst;
    free_b           = FreeBRst;
    src_idle_pct     = 23;
    sink_idle_pct    = 57;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_each_edge();
    test_field_extremes();
    test_unused_and_last_tile();
    test_zero_width();
    test_back_pressure();
    test_random_settings();
    wait_idle();

    $display("Sent %0d words under %0d register settings, all four edges and unused opcodes.",
             words_sent, settings_used);
    $display("Checked %0d result words, %0d of them hits; %0d mismatches.",
             results_seen, hits_seen, err_count);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Run timed out.");
    $display("Test completed with failures");
    $finish;
  end

endmodule
